// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; define ASSERT_OFF to drop.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Flag any clock edge at which expr holds.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// Whenever ante holds, cons must hold on the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/llc_pkg.sv -----
// ----------------------------------------------------------------------------
// LogLog counter package
// Field widths, fixed-point constants, the 2^(2^-k) table and the rank helper.
// ----------------------------------------------------------------------------
package llc_pkg;

    localparam int HASH_BITS      = 64;
    localparam int RANK_WORD_BITS = 32;
    localparam int RANK_BITS      = 5;
    localparam int EST_BITS       = 31;

    // 2^fraction accumulator in Q1.23
    localparam int P_BITS     = 24;
    localparam int P_FRAC     = 23;
    localparam int PROD_BITS  = 2 * P_BITS;
    localparam int FRAC_STEPS = 16;

    // alpha in Q0.32, product with the accumulator in Q1.55
    localparam int ALPHA_BITS = 32;
    localparam int M_BITS     = ALPHA_BITS + P_BITS;
    localparam int M_FRAC     = ALPHA_BITS + P_FRAC;

    typedef logic [HASH_BITS-1:0]      hash_t;
    typedef logic [RANK_WORD_BITS-1:0] rank_word_t;
    typedef logic [RANK_BITS-1:0]      rank_t;
    typedef logic [EST_BITS-1:0]       estimate_t;
    typedef logic [P_BITS-1:0]         pow_t;
    typedef logic [M_BITS-1:0]         scaled_t;

    localparam logic [ALPHA_BITS-1:0] ALPHA_Q32 = 32'd3410289932;
    localparam pow_t                  P_ONE     = 24'd8388608;
    localparam logic [PROD_BITS-1:0]  P_HALF    = 48'd4194304;
    localparam estimate_t             EST_MAX   = 31'h7FFF_FFFF;

    // round(2^(2^-(k+1)) * 2^23) for k = 0..15
    localparam pow_t POW2_FRAC_Q23 [FRAC_STEPS] = '{
        24'd11863283, 24'd9975792, 24'd9147842, 24'd8760003,
        24'd8572295,  24'd8479954, 24'd8434157, 24'd8411352,
        24'd8399972,  24'd8394288, 24'd8391448, 24'd8390028,
        24'd8389318,  24'd8388963, 24'd8388785, 24'd8388697
    };

    // Trailing-zero count; an all-zero word ranks as zero.
    function automatic rank_t rank_of(input rank_word_t w);
        rank_word_t lowest;
        rank_t      rk;
        lowest = w & (~w + 1'b1);
        rk     = '0;
        for (int i = 0; i < RANK_WORD_BITS; i++) begin
            if (lowest[i])
            begin
                rk = rk | RANK_BITS'(i);
            end
        end
        return rk;
    endfunction

endpackage

// ----- sv/llc_if.sv -----
// ----------------------------------------------------------------------------
// LogLog counter channels
// Valid/ready stream interfaces for hashed items and for estimates.
// ----------------------------------------------------------------------------
interface llc_in_if
    import llc_pkg::*;
();
    logic  valid;
    logic  ready;
    hash_t item_hash;

    modport source (output valid, output item_hash, input ready);
    modport sink   (input valid, input item_hash, output ready);
endinterface

interface llc_out_if
    import llc_pkg::*;
();
    logic      valid;
    logic      ready;
    estimate_t estimate;

    modport source (output valid, output estimate, input ready);
    modport sink   (input valid, input estimate, output ready);
endinterface

// ----- sv/llc_rank_update.sv -----
// ----------------------------------------------------------------------------
// LogLog bucket update
// Bucket maxima store with read-modify-write, forwarding and running sum.
// ----------------------------------------------------------------------------
module llc_rank_update
    import llc_pkg::*;
#(
    parameter int BUCKET_BITS = 10
)(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  hash_t                          item_hash,
    output logic                           busy,
    output logic                           sum_valid,
    output logic [RANK_BITS+BUCKET_BITS-1:0] sum
);

    localparam int BUCKET_COUNT = 1 << BUCKET_BITS;
    localparam int SUM_W        = RANK_BITS + BUCKET_BITS;

    logic [RANK_BITS-1:0]   bucket_mem [BUCKET_COUNT];

    logic [BUCKET_BITS-1:0] idx_in;
    rank_t                  rank_in;

    logic                   a_valid_reg;
    logic [BUCKET_BITS-1:0] a_idx_reg;
    rank_t                  a_rank_reg;
    rank_t                  rd_data_reg;

    logic                   byp_valid_reg;
    logic [BUCKET_BITS-1:0] byp_idx_reg;
    rank_t                  byp_data_reg;

    logic                   clr_active_reg;
    logic [BUCKET_BITS-1:0] clr_idx_reg;

    rank_t                  old_max;
    logic                   raise;
    rank_t                  new_max;
    logic [SUM_W-1:0]       sum_next;

    logic                   wr_en;
    logic [BUCKET_BITS-1:0] wr_idx;
    rank_t                  wr_data;

    logic                   sum_valid_reg;
    logic [SUM_W-1:0]       sum_reg;

    assign idx_in  = item_hash[BUCKET_BITS-1:0];
    assign rank_in = rank_of(item_hash[BUCKET_BITS +: RANK_WORD_BITS]);

    // Take the value written on the previous edge when it hits the same bucket
    always_comb
    begin
        if (byp_valid_reg && (byp_idx_reg == a_idx_reg))
        begin
            old_max = byp_data_reg;
        end
        else
        begin
            old_max = rd_data_reg;
        end
        raise    = a_rank_reg > old_max;
        new_max  = raise ? a_rank_reg : old_max;
        sum_next = sum_reg + SUM_W'(raise ? (a_rank_reg - old_max) : '0);
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = clr_idx_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = a_valid_reg && raise;
            wr_idx  = a_idx_reg;
            wr_data = new_max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bucket_mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= bucket_mem[idx_in];
        end
    end

    // Sweep every bucket to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (&clr_idx_reg)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else
        begin
            a_valid_reg   <= accept;
            byp_valid_reg <= a_valid_reg;
            sum_valid_reg <= a_valid_reg;
            if (a_valid_reg && raise)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_idx_reg  <= idx_in;
            a_rank_reg <= rank_in;
        end
        byp_idx_reg  <= a_idx_reg;
        byp_data_reg <= new_max;
    end

    assign busy      = clr_active_reg;
    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

endmodule

// ----- sv/llc_estimate.sv -----
// ----------------------------------------------------------------------------
// LogLog estimate pipeline
// 2^(sum/m) in Q1.23, one fraction bit per stage, then alpha scale and shift.
// ----------------------------------------------------------------------------
module llc_estimate
    import llc_pkg::*;
#(
    parameter int BUCKET_BITS = 10
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sum_valid,
    input  logic [RANK_BITS+BUCKET_BITS-1:0] sum,
    output logic                             est_valid,
    output estimate_t                        estimate
);

    localparam int SHIFT_W = 6;

    logic                   v_reg [BUCKET_BITS];
    pow_t                   p_reg [BUCKET_BITS];
    rank_t                  q_reg [BUCKET_BITS];
    logic [BUCKET_BITS-1:0] r_reg [BUCKET_BITS];

    pow_t                   p_in   [BUCKET_BITS];
    rank_t                  q_in   [BUCKET_BITS];
    logic [BUCKET_BITS-1:0] r_in   [BUCKET_BITS];
    pow_t                   p_step [BUCKET_BITS];
    logic [PROD_BITS-1:0]   prod   [BUCKET_BITS];
    logic [PROD_BITS-1:0]   rnd    [BUCKET_BITS];

    logic                   m_valid_reg;
    scaled_t                m_reg;
    rank_t                  mq_reg;

    logic [SHIFT_W-1:0]     shift_amt;
    scaled_t                shifted;
    estimate_t              est_next;

    logic                   est_valid_reg;
    estimate_t              est_reg;

    always_comb
    begin
        p_in[0] = P_ONE;
        q_in[0] = sum[RANK_BITS+BUCKET_BITS-1:BUCKET_BITS];
        r_in[0] = sum[BUCKET_BITS-1:0];
        for (int k = 1; k < BUCKET_BITS; k++)
        begin
            p_in[k] = p_reg[k-1];
            q_in[k] = q_reg[k-1];
            r_in[k] = r_reg[k-1];
        end
        // Multiply by 2^(2^-(k+1)) and round back to Q1.23
        for (int k = 0; k < BUCKET_BITS; k++)
        begin
            prod[k]   = PROD_BITS'(p_in[k]) * PROD_BITS'(POW2_FRAC_Q23[k]);
            rnd[k]    = prod[k] + P_HALF;
            p_step[k] = rnd[k][P_FRAC +: P_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BUCKET_BITS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            m_valid_reg   <= 1'b0;
            est_valid_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= sum_valid;
            for (int k = 1; k < BUCKET_BITS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            m_valid_reg   <= v_reg[BUCKET_BITS-1];
            est_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BUCKET_BITS; k++)
        begin
            p_reg[k] <= r_in[k][BUCKET_BITS-1-k] ? p_step[k] : p_in[k];
            q_reg[k] <= q_in[k];
            r_reg[k] <= r_in[k];
        end
        m_reg   <= M_BITS'(ALPHA_Q32) * M_BITS'(p_reg[BUCKET_BITS-1]);
        mq_reg  <= q_reg[BUCKET_BITS-1];
        est_reg <= est_next;
    end

    // Q1.55 down to an integer scaled by m * 2^q, truncating and saturating at EST_MAX
    always_comb
    begin
        shift_amt = SHIFT_W'(M_FRAC - BUCKET_BITS) - SHIFT_W'(mq_reg);
        shifted   = m_reg >> shift_amt;
        if (shifted > M_BITS'(EST_MAX))
        begin
            est_next = EST_MAX;
        end
        else
        begin
            est_next = shifted[EST_BITS-1:0];
        end
    end

    assign est_valid = est_valid_reg;
    assign estimate  = est_reg;

endmodule

// ----- sv/loglog_distinct_counter.sv -----
// ----------------------------------------------------------------------------
// LogLog distinct-count estimator
// Throughput: one item per cycle; credit-gated result queue of BUCKET_BITS + 6.
// Reset: clears the sum, then sweeps all 2^BUCKET_BITS buckets to zero
// (1024 by default) with items.ready held low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module loglog_distinct_counter
    import llc_pkg::*;
#(
    parameter int BUCKET_BITS = 10
)(
    input  logic             clk,
    input  logic             rst_n,
    llc_in_if.sink           items,
    llc_out_if.source        estimates
);

    localparam int SUM_W = RANK_BITS + BUCKET_BITS;
    localparam int DEPTH = BUCKET_BITS + 6;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             busy;
    logic             sum_valid;
    logic [SUM_W-1:0] sum;
    logic             est_valid;
    estimate_t        est;

    logic             accept;
    logic             deliver;

    estimate_t        fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fifo_cnt_reg;
    logic [CNT_W-1:0] fifo_cnt_next;
    logic [CNT_W-1:0] outstanding_reg;
    logic [CNT_W-1:0] outstanding_next;

    llc_rank_update #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_rank_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item_hash (items.item_hash),
        .busy      (busy),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    llc_estimate #(
        .BUCKET_BITS (BUCKET_BITS)
    ) u_estimate (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum       (sum),
        .est_valid (est_valid),
        .estimate  (est)
    );

    // Admit an item only while a queue slot is reserved for its result
    assign items.ready = !busy && (outstanding_reg < CNT_W'(DEPTH));
    assign accept      = items.valid && items.ready;

    assign estimates.valid    = fifo_cnt_reg != '0;
    assign estimates.estimate = fifo_mem[rd_ptr_reg];
    assign deliver            = estimates.valid && estimates.ready;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (accept && !deliver)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (deliver && !accept)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end

        fifo_cnt_next = fifo_cnt_reg;
        if (est_valid && !deliver)
        begin
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        end
        else if (deliver && !est_valid)
        begin
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            fifo_cnt_reg    <= '0;
            outstanding_reg <= '0;
        end
        else
        begin
            fifo_cnt_reg    <= fifo_cnt_next;
            outstanding_reg <= outstanding_next;
            if (est_valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (deliver)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (est_valid)
        begin
            fifo_mem[wr_ptr_reg] <= est;
        end
    end

    `ASSERT_NEVER(a_queue_overflow, clk, rst_n, est_valid && (fifo_cnt_reg == CNT_W'(DEPTH)), "estimate written into a full queue")
    `ASSERT_IMPLIES(a_result_has_credit, clk, rst_n, est_valid, outstanding_reg > fifo_cnt_reg, "estimate without an outstanding item")
    `ASSERT_NEVER(a_credit_bound, clk, rst_n, outstanding_reg > CNT_W'(DEPTH), "more items in flight than queue slots")

endmodule
